// ===== src/sadjl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted adjacency list store: shared types and constants
// Field widths, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package sadjl_pkg;

  localparam int FUNC_W   = 3;
  localparam int VTX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 11;
  localparam int CFG_W    = 7;

  localparam int VALUE_MAX = 2047;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_CHECK  = 3'd2,
    FUNC_DEGREE = 3'd3,
    FUNC_LIST   = 3'd4,
    FUNC_TOTAL  = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN,
    ST_SEEK,
    ST_SHUP,
    ST_SHDN,
    ST_INS,
    ST_FIN,
    ST_LIST,
    ST_RESP
  } state_e;

endpackage

// ===== src/sorted_adjacency_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted adjacency list store
// Directed weighted graph kept as one sorted edge row per vertex, updated
// and queried by a small sequencer around one edge memory.
// One item is in work at a time; the walk over the row through the edge
// memory, one entry per cycle while a list is not held by an output stall,
// sets the rate. After reset the row lengths are cleared in a pass over all
// MAX_VERTICES rows (64 by default), during which no input transfer is taken.
// ----------------------------------------------------------------------------
module sorted_adjacency_list_store_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sadjl_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sadjl_pkg::FUNC_W-1:0]     func_i,
  input  logic [sadjl_pkg::VTX_W-1:0]      from_vertex_i,
  input  logic [sadjl_pkg::VTX_W-1:0]      to_vertex_i,
  input  logic signed [sadjl_pkg::WEIGHT_W-1:0] weight_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sadjl_pkg::STATUS_W-1:0]   status_o,
  output logic                             found_o,
  output logic [sadjl_pkg::VALUE_W-1:0]    value_o,
  output logic                             last_o
);
  import sadjl_pkg::*;

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int DW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LW     = $clog2(MAX_DEGREE + 1);
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int TW     = $clog2(MAX_VERTICES * MAX_DEGREE + 1);
  localparam int EW     = VTX_W + WEIGHT_BITS;
  localparam int EAW    = VW + DW;
  localparam int EDEPTH = MAX_VERTICES * (2 ** DW);

  function automatic logic [EAW-1:0] ea(input logic [VW-1:0] r, input int s);
    return {r, DW'(s)};
  endfunction

  state_e                 state_q, state_d;
  func_e                  func_q, func_d;
  logic [VW-1:0]          row_q, row_d;
  logic [VTX_W-1:0]       to_q, to_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic [LW-1:0]          len_q, len_d;
  logic [LW-1:0]          idx_q, idx_d;
  logic [LW-1:0]          ptr_q, ptr_d;
  logic [VW-1:0]          clr_q, clr_d;
  logic [CW-1:0]          vcount_q, vcount_d;
  logic [TW-1:0]          total_q, total_d;
  status_e                res_status_q, res_status_d;
  logic                   res_found_q, res_found_d;
  logic [VALUE_W-1:0]     res_value_q, res_value_d;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q;
  logic                   out_found_q;
  logic [VALUE_W-1:0]     out_value_q;
  logic                   out_last_q;
  logic                   out_load;
  status_e                o_status;
  logic                   o_found;
  logic [VALUE_W-1:0]     o_value;
  logic                   o_last;
  logic                   out_free;

  logic [EW-1:0]          edge_mem [EDEPTH];
  logic [EW-1:0]          em_rdata_q;
  logic [EAW-1:0]         em_raddr, em_waddr;
  logic [EW-1:0]          em_wdata;
  logic                   em_we;

  logic [LW-1:0]          rl_mem [MAX_VERTICES];
  logic [LW-1:0]          rl_rdata_q;
  logic [VW-1:0]          rl_waddr;
  logic [LW-1:0]          rl_wdata;
  logic                   rl_we;

  logic                   accept;
  logic                   add_bad, use_bad;
  logic [VTX_W-1:0]       ent_tgt;
  logic                   ent_valid, tgt_gt, tgt_eq, seek_adv, hit;
  logic [VALUE_W-1:0]     total_sat;
  logic [CW-1:0]          cfg_clamped;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign add_bad = 32'(from_vertex_i) >= MAX_VERTICES;
  assign use_bad = add_bad || (32'(from_vertex_i) >= 32'(vcount_q));

  assign ent_tgt   = em_rdata_q[WEIGHT_BITS +: VTX_W];
  assign ent_valid = idx_q < len_q;
  assign tgt_gt    = to_q > ent_tgt;
  assign tgt_eq    = to_q == ent_tgt;
  assign seek_adv  = ent_valid && tgt_gt;
  assign hit       = ent_valid && tgt_eq;

  assign total_sat = (32'(total_q) > VALUE_MAX) ? VALUE_W'(VALUE_MAX) : VALUE_W'(total_q);

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_clamped = CW'(1);
    end else if (32'(cfg_wdata_i) > MAX_VERTICES) begin
      cfg_clamped = CW'(MAX_VERTICES);
    end else begin
      cfg_clamped = CW'(cfg_wdata_i);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (32'(clr_q) == MAX_VERTICES - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (func_e'(func_i))
            FUNC_ADD:    state_d = add_bad ? ST_RESP : ST_LEN;
            FUNC_REMOVE,
            FUNC_CHECK,
            FUNC_DEGREE,
            FUNC_LIST:   state_d = use_bad ? ST_RESP : ST_LEN;
            FUNC_TOTAL:  state_d = ST_RESP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_LEN: begin
        if (func_q == FUNC_DEGREE) begin
          state_d = ST_RESP;
        end else if (func_q == FUNC_LIST) begin
          state_d = (rl_rdata_q == '0) ? ST_RESP : ST_LIST;
        end else begin
          state_d = ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (!seek_adv) begin
          priority if (func_q == FUNC_ADD) begin
            if (hit || 32'(len_q) == MAX_DEGREE) begin
              state_d = ST_RESP;
            end else if (len_q > idx_q) begin
              state_d = ST_SHUP;
            end else begin
              state_d = ST_INS;
            end
          end else if (func_q == FUNC_REMOVE && hit) begin
            state_d = (32'(idx_q) + 1 < 32'(len_q)) ? ST_SHDN : ST_FIN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SHUP: begin
        if (32'(ptr_q) - 1 == 32'(idx_q)) state_d = ST_INS;
      end
      ST_SHDN: begin
        if (!(32'(ptr_q) + 2 < 32'(len_q))) state_d = ST_FIN;
      end
      ST_INS:  state_d = ST_RESP;
      ST_FIN:  state_d = ST_RESP;
      ST_LIST: begin
        if (out_free && (32'(idx_q) + 1 == 32'(len_q))) state_d = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    func_d       = func_q;
    row_d        = row_q;
    to_d         = to_q;
    w_d          = w_q;
    len_d        = len_q;
    idx_d        = idx_q;
    ptr_d        = ptr_q;
    clr_d        = clr_q;
    vcount_d     = vcount_q;
    total_d      = total_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_value_d  = res_value_q;
    em_raddr     = ea(row_q, int'(idx_q));
    em_we        = 1'b0;
    em_waddr     = ea(row_q, int'(idx_q));
    em_wdata     = {to_q, w_q};
    rl_we        = 1'b0;
    rl_waddr     = row_q;
    rl_wdata     = len_q;
    out_load     = 1'b0;
    o_status     = res_status_q;
    o_found      = res_found_q;
    o_value      = res_value_q;
    o_last       = 1'b1;

    unique case (state_q)
      ST_CLEAR: begin
        rl_we    = 1'b1;
        rl_waddr = clr_q;
        rl_wdata = '0;
        clr_d    = clr_q + VW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          func_d       = func_e'(func_i);
          row_d        = VW'(from_vertex_i);
          to_d         = to_vertex_i;
          w_d          = WEIGHT_BITS'($unsigned(weight_i));
          res_status_d = STAT_OK;
          res_found_d  = 1'b0;
          res_value_d  = '0;
          if (func_e'(func_i) == FUNC_TOTAL) begin
            res_value_d = total_sat;
          end else if (func_e'(func_i) == FUNC_ADD) begin
            if (add_bad) begin
              res_status_d = STAT_RANGE;
            end else if (32'(from_vertex_i) >= 32'(vcount_q)) begin
              vcount_d = CW'(32'(from_vertex_i) + 1);
            end
          end else if (use_bad) begin
            res_status_d = STAT_RANGE;
          end
        end
      end
      ST_LEN: begin
        len_d    = rl_rdata_q;
        idx_d    = '0;
        em_raddr = ea(row_q, 0);
        if (func_q == FUNC_DEGREE) begin
          res_value_d = VALUE_W'(rl_rdata_q);
        end else if (func_q == FUNC_LIST && rl_rdata_q == '0) begin
          res_status_d = STAT_NOT_FOUND;
        end
      end
      ST_SEEK: begin
        if (seek_adv) begin
          idx_d    = idx_q + LW'(1);
          em_raddr = ea(row_q, int'(idx_q) + 1);
        end else begin
          priority if (func_q == FUNC_ADD) begin
            if (hit) begin
              em_we = 1'b1;
            end else if (32'(len_q) == MAX_DEGREE) begin
              res_status_d = STAT_FULL;
            end else if (len_q > idx_q) begin
              em_raddr = ea(row_q, int'(len_q) - 1);
              ptr_d    = len_q;
            end
          end else if (func_q == FUNC_REMOVE) begin
            if (hit) begin
              em_raddr = ea(row_q, int'(idx_q) + 1);
              ptr_d    = idx_q;
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end else begin
            if (hit) begin
              res_found_d = 1'b1;
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
        end
      end
      ST_SHUP: begin
        em_we    = 1'b1;
        em_waddr = ea(row_q, int'(ptr_q));
        em_wdata = em_rdata_q;
        em_raddr = ea(row_q, int'(ptr_q) - 2);
        ptr_d    = ptr_q - LW'(1);
      end
      ST_SHDN: begin
        em_we    = 1'b1;
        em_waddr = ea(row_q, int'(ptr_q));
        em_wdata = em_rdata_q;
        em_raddr = ea(row_q, int'(ptr_q) + 2);
        ptr_d    = ptr_q + LW'(1);
      end
      ST_INS: begin
        em_we    = 1'b1;
        rl_we    = 1'b1;
        rl_wdata = len_q + LW'(1);
        total_d  = total_q + TW'(1);
      end
      ST_FIN: begin
        rl_we       = 1'b1;
        rl_wdata    = len_q - LW'(1);
        res_found_d = 1'b1;
        if (total_q != '0) total_d = total_q - TW'(1);
      end
      ST_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = STAT_OK;
          o_found  = 1'b0;
          o_value  = VALUE_W'(ent_tgt);
          o_last   = (32'(idx_q) + 1 == 32'(len_q));
          idx_d    = idx_q + LW'(1);
          em_raddr = ea(row_q, int'(idx_q) + 1);
        end
      end
      ST_RESP: begin
        out_load = out_free;
      end
      default: begin
        clr_d = '0;
      end
    endcase

    if (cfg_we_i) begin
      if (total_q == '0) begin
        vcount_d = cfg_clamped;
      end else if (cfg_clamped > vcount_q) begin
        vcount_d = cfg_clamped;
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      vcount_q    <= CW'(1);
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      vcount_q    <= vcount_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    row_q        <= row_d;
    to_q         <= to_d;
    w_q          <= w_d;
    len_q        <= len_d;
    idx_q        <= idx_d;
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= o_status;
      out_found_q  <= o_found;
      out_value_q  <= o_value;
      out_last_q   <= o_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_we) edge_mem[em_waddr] <= em_wdata;
    em_rdata_q <= edge_mem[em_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) rl_mem[rl_waddr] <= rl_wdata;
    rl_rdata_q <= rl_mem[VW'(from_vertex_i)];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a stalled transfer");

  a_seek_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEEK |-> (idx_q <= len_q) && (32'(len_q) <= MAX_DEGREE))
    else $error("row walk index beyond row length");

  a_edge_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_we |-> (state_q == ST_SEEK || state_q == ST_SHUP || state_q == ST_SHDN ||
               state_q == ST_INS))
    else $error("edge memory written outside an update");

  a_row_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rl_we |-> 32'(rl_wdata) <= MAX_DEGREE)
    else $error("row length written beyond row capacity");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INS |=> total_q == $past(total_q) + TW'(1))
    else $error("edge total not advanced on insert");

endmodule

// ===== verif/sorted_adjacency_list_store_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Sorted adjacency list store testbench
// Drives graph operations through the valid/stall input channel and checks
// every result against a shadow copy of the graph, kept as sorted target
// rows, that is updated as each operation is transferred. Phases vary the
// vertex count register and the idle patterns of both channels.
// ----------------------------------------------------------------------------
module sorted_adjacency_list_store_unit_tb;
  import sadjl_pkg::*;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int RANDOM_PER_PHASE = 85;
  localparam int SETTLE_CYCLES = 50;
  localparam int CLEAR_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic [VTX_W-1:0]           from_v;
    logic [VTX_W-1:0]           to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } graph_op_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [VALUE_W-1:0] value;
    logic               last;
  } graph_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [VTX_W-1:0] from_vertex_i = '0;
  logic [VTX_W-1:0] to_vertex_i = '0;
  logic signed [WEIGHT_W-1:0] weight_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic found_o;
  logic [VALUE_W-1:0] value_o;
  logic last_o;

  graph_op_t pending_ops[$];
  graph_op_t held_op;
  graph_reply_t expected_replies[$];

  logic [VTX_W-1:0] row_target [MAX_VERTICES][MAX_DEGREE];
  int row_len [MAX_VERTICES];
  int vtx_count = 1;
  int edge_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  sorted_adjacency_list_store_unit #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_DEGREE  (MAX_DEGREE),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void push_reply(status_e s, logic f, int v, logic l);
    graph_reply_t r;
    r.status = s;
    r.found = f;
    r.value = VALUE_W'(v);
    r.last = l;
    expected_replies = {expected_replies, r};
  endfunction

  // Applies one transferred operation to the shadow graph and queues the
  // results it must produce.
  function automatic void graph_apply_op(graph_op_t op);
    int fv;
    int len;
    int pos;
    bit hit;
    fv = op.from_v;
    if (op.func == FUNC_RSVD6 || op.func == FUNC_RSVD7) return;
    if (op.func == FUNC_TOTAL) begin
      push_reply(STAT_OK, 1'b0, (edge_count > VALUE_MAX) ? VALUE_MAX : edge_count, 1'b1);
      return;
    end
    if (op.func == FUNC_ADD) begin
      if (fv >= vtx_count) vtx_count = fv + 1;
    end else if (fv >= vtx_count) begin
      push_reply(STAT_RANGE, 1'b0, 0, 1'b1);
      return;
    end
    len = row_len[fv];
    pos = 0;
    while (pos < len && op.to_v > row_target[fv][pos]) pos++;
    hit = (pos < len) && (row_target[fv][pos] == op.to_v);
    case (op.func)
      FUNC_ADD: begin
        if (hit) begin
          push_reply(STAT_OK, 1'b0, 0, 1'b1);
        end else if (len >= MAX_DEGREE) begin
          push_reply(STAT_FULL, 1'b0, 0, 1'b1);
        end else begin
          for (int j = len; j > pos; j--) row_target[fv][j] = row_target[fv][j-1];
          row_target[fv][pos] = op.to_v;
          row_len[fv] = len + 1;
          edge_count++;
          push_reply(STAT_OK, 1'b0, 0, 1'b1);
        end
      end
      FUNC_REMOVE: begin
        if (!hit) begin
          push_reply(STAT_NOT_FOUND, 1'b0, 0, 1'b1);
        end else begin
          for (int j = pos; j + 1 < len; j++) row_target[fv][j] = row_target[fv][j+1];
          row_len[fv] = len - 1;
          if (edge_count > 0) edge_count--;
          push_reply(STAT_OK, 1'b1, 0, 1'b1);
        end
      end
      FUNC_CHECK: begin
        if (hit) push_reply(STAT_OK, 1'b1, 0, 1'b1);
        else push_reply(STAT_NOT_FOUND, 1'b0, 0, 1'b1);
      end
      FUNC_DEGREE: begin
        push_reply(STAT_OK, 1'b0, len, 1'b1);
      end
      default: begin
        if (len == 0) begin
          push_reply(STAT_NOT_FOUND, 1'b0, 0, 1'b1);
        end else begin
          for (int i = 0; i < len; i++) begin
            push_reply(STAT_OK, 1'b0, row_target[fv][i], (i == len - 1));
          end
        end
      end
    endcase
  endfunction

  // While the graph is empty the register sets the vertex count outright,
  // otherwise the count can only grow.
  function automatic void graph_load_vertices(logic [CFG_W-1:0] v);
    int c;
    c = v;
    if (c < 1) c = 1;
    if (c > MAX_VERTICES) c = MAX_VERTICES;
    if (edge_count == 0) vtx_count = c;
    else if (c > vtx_count) vtx_count = c;
  endfunction

  function automatic void queue_op(logic [FUNC_W-1:0] f, int fv, int tv,
                                   logic [WEIGHT_W-1:0] w);
    graph_op_t op;
    op.func = f;
    op.from_v = VTX_W'(fv);
    op.to_v = VTX_W'(tv);
    op.weight = w;
    pending_ops = {pending_ops, op};
  endfunction

  function automatic void queue_directed_ops();
    queue_op(FUNC_TOTAL, 0, 0, 16'h0000);
    queue_op(FUNC_LIST, 0, 0, 16'h0000);
    queue_op(FUNC_DEGREE, 0, 0, 16'h0000);
    queue_op(FUNC_CHECK, 0, 5, 16'h0000);
    queue_op(FUNC_REMOVE, 0, 5, 16'h0000);
    queue_op(FUNC_CHECK, 1, 0, 16'h0000);
    queue_op(FUNC_REMOVE, 63, 63, 16'hffff);
    queue_op(FUNC_DEGREE, 63, 0, 16'h0000);
    queue_op(FUNC_LIST, 63, 0, 16'h0000);
    queue_op(FUNC_ADD, 0, 63, 16'h8000);
    queue_op(FUNC_ADD, 0, 0, 16'h7fff);
    queue_op(FUNC_ADD, 0, 63, 16'h0000);
    queue_op(FUNC_ADD, 0, 30, 16'h0001);
    queue_op(FUNC_CHECK, 0, 30, 16'h0000);
    queue_op(FUNC_CHECK, 0, 31, 16'h0000);
    queue_op(FUNC_LIST, 0, 0, 16'h0000);
    queue_op(FUNC_REMOVE, 0, 30, 16'h0000);
    queue_op(FUNC_REMOVE, 0, 40, 16'h0000);
    queue_op(FUNC_REMOVE, 0, 63, 16'h0000);
    queue_op(FUNC_REMOVE, 0, 9, 16'h0000);
    queue_op(FUNC_ADD, 63, 1, 16'hffff);
    queue_op(FUNC_DEGREE, 63, 0, 16'h0000);
    queue_op(FUNC_RSVD6, 63, 63, 16'hffff);
    queue_op(FUNC_RSVD7, 0, 0, 16'h0000);
    queue_op(FUNC_TOTAL, 63, 63, 16'hffff);
  endfunction

  // Mostly operations on a few busy rows with a narrow target range, so rows
  // fill up and shift often, plus row fills past capacity and raw noise.
  function automatic void queue_random_ops(int n);
    int added;
    int pick;
    int v;
    logic [FUNC_W-1:0] f;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        v = $urandom_range(0, 7);
        for (int k = 0; k < MAX_DEGREE + 3; k++) begin
          queue_op(FUNC_ADD, v, $urandom_range(0, 63), WEIGHT_W'($urandom));
        end
        queue_op(FUNC_LIST, v, 0, 16'h0000);
        added += MAX_DEGREE + 4;
      end else if (pick < 25) begin
        f = FUNC_W'($urandom_range(0, 7));
        queue_op(f, $urandom_range(0, 63), $urandom_range(0, 63), WEIGHT_W'($urandom));
        if (f != FUNC_RSVD6 && f != FUNC_RSVD7) added++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) f = FUNC_ADD;
        else if (pick < 55) f = FUNC_REMOVE;
        else if (pick < 70) f = FUNC_CHECK;
        else if (pick < 78) f = FUNC_DEGREE;
        else if (pick < 92) f = FUNC_LIST;
        else if (pick < 97) f = FUNC_TOTAL;
        else f = $urandom_range(0, 1) ? FUNC_RSVD7 : FUNC_RSVD6;
        queue_op(f, $urandom_range(0, 7), $urandom_range(0, 23), WEIGHT_W'($urandom));
        if (f != FUNC_RSVD6 && f != FUNC_RSVD7) added++;
      end
    end
  endfunction

  // Removes every edge, always the first of its row, so each removal but the last of a row shifts.
  function automatic void queue_teardown_ops();
    for (int v = 0; v < MAX_VERTICES; v++) begin
      for (int k = 0; k < row_len[v]; k++) begin
        queue_op(FUNC_REMOVE, v, row_target[v][k], 16'h0000);
      end
    end
    queue_op(FUNC_TOTAL, 0, 0, 16'h0000);
  endfunction

  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_cfg(logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    graph_load_vertices(v);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) graph_apply_op(held_op);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          held_op = pending_ops.pop_front();
          in_valid_i <= 1'b1;
          func_i <= held_op.func;
          from_vertex_i <= held_op.from_v;
          to_vertex_i <= held_op.to_v;
          weight_i <= held_op.weight;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void report_mismatch(string field, int exp_v, int act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin
    graph_reply_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                   $time, status_o, value_o);
          mismatch_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (status_o !== exp_r.status) report_mismatch("status", exp_r.status, status_o);
          if (found_o !== exp_r.found) report_mismatch("found", exp_r.found, found_o);
          if (value_o !== exp_r.value) report_mismatch("value", exp_r.value, value_o);
          if (last_o !== exp_r.last) report_mismatch("last", exp_r.last, last_o);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] cfg_plan [4];
    int send_plan [4];
    int recv_plan [4];
    cfg_plan = '{7'd0, 7'd127, 7'd64, CFG_W'($urandom_range(2, 8))};
    send_plan = '{0, 79, 0, 12};
    recv_plan = '{0, 0, 79, 12};
    for (int v = 0; v < MAX_VERTICES; v++) row_len[v] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The row lengths are cleared in a pass after reset.
    repeat (CLEAR_CYCLES) @(posedge clk_i);
    for (int phase = 0; phase < 4; phase++) begin
      wait_until_drained();
      if (phase == 3) begin
        queue_teardown_ops();
        wait_until_drained();
      end
      write_vertex_cfg(cfg_plan[phase]);
      send_idle_pct = send_plan[phase];
      recv_stall_pct = recv_plan[phase];
      if (phase == 0) queue_directed_ops();
      queue_random_ops(RANDOM_PER_PHASE);
    end
    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sadjl_pkg.sv
src/sorted_adjacency_list_store_unit.sv
verif/sorted_adjacency_list_store_unit_tb.sv
